/* rtl/bfe_pkg.sv */
package bfe_pkg;

   localparam int MAX_FILTER_BITS = 1024;
   localparam int MAX_HASHES      = 16;
   localparam int ADDR_W          = $clog2(MAX_FILTER_BITS);
   localparam int FB_W            = 11;
   localparam int HC_W            = 5;
   localparam int HASH_W          = 32;
   localparam int BYTE_W          = 8;
   localparam int DIV_BITS        = 4;
   localparam int DIV_STEPS       = HASH_W / DIV_BITS;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W       = 2;

   localparam logic [HASH_W-1:0] DJB_START = 32'd5381;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_BITS = 2'd0,
      CSR_HASH_COUNT  = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_ACCESS,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic absorb;
      logic load;
      logic div_step;
      logic next_probe;
      logic write_bit;
      logic read_bit;
   } cmd_type;

   typedef struct packed {
      logic            clear_last;
      logic [HC_W-1:0] count;
      logic            rd_bit;
   } status_type;

endpackage

/* rtl/bfe_ctrl.sv */
module bfe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_present,
   output bfe_pkg::cmd_type     cmd,
   input  bfe_pkg::status_type  st
);

   bfe_pkg::state_type                state_ff, state_in;
   logic [bfe_pkg::HC_W-1:0]          probe_ff, probe_in;
   logic [bfe_pkg::DIV_CNT_W-1:0]     div_ff, div_in;
   bfe_pkg::op_type                   op_ff, op_in;
   logic                              hit_ff, hit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_present_ff, rsp_present_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfe_pkg::ST_CLEAR;
         probe_ff     <= '0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_ff     <= probe_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      hit_ff         <= hit_in;
      rsp_present_ff <= rsp_present_in;
   end

   always_comb begin
      state_in       = state_ff;
      probe_in       = probe_ff;
      div_in         = div_ff;
      op_in          = op_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_present_in = rsp_present_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      unique case (state_ff)
         bfe_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_last) begin
               state_in = bfe_pkg::ST_IDLE;
            end
         end
         bfe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.absorb = 1'b1;
               if (req_last_byte) begin
                  cmd.load = 1'b1;
                  op_in    = bfe_pkg::op_type'(req_opcode);
                  probe_in = '0;
                  div_in   = '0;
                  if (st.count == '0) begin
                     if (req_opcode == bfe_pkg::OP_QUERY) begin
                        hit_in   = 1'b1;
                        state_in = bfe_pkg::ST_DONE;
                     end
                  end else begin
                     state_in = bfe_pkg::ST_DIVIDE;
                  end
               end
            end
         end
         bfe_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_in = div_ff + bfe_pkg::DIV_CNT_W'(1);
            if (div_ff == bfe_pkg::DIV_CNT_W'(bfe_pkg::DIV_STEPS - 1)) begin
               state_in = bfe_pkg::ST_ACCESS;
            end
         end
         bfe_pkg::ST_ACCESS: begin
            probe_in = probe_ff + bfe_pkg::HC_W'(1);
            if (op_ff == bfe_pkg::OP_INSERT) begin
               cmd.write_bit = 1'b1;
               if (probe_in == st.count) begin
                  state_in = bfe_pkg::ST_IDLE;
               end else begin
                  cmd.next_probe = 1'b1;
                  div_in         = '0;
                  state_in       = bfe_pkg::ST_DIVIDE;
               end
            end else begin
               cmd.read_bit = 1'b1;
               state_in     = bfe_pkg::ST_CHECK;
            end
         end
         bfe_pkg::ST_CHECK: begin
            if (!st.rd_bit) begin
               hit_in   = 1'b0;
               state_in = bfe_pkg::ST_DONE;
            end else if (probe_ff == st.count) begin
               hit_in   = 1'b1;
               state_in = bfe_pkg::ST_DONE;
            end else begin
               cmd.next_probe = 1'b1;
               div_in         = '0;
               state_in       = bfe_pkg::ST_DIVIDE;
            end
         end
         bfe_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = hit_ff;
               state_in       = bfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfe_pkg::ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;

endmodule

/* rtl/bfe_dp.sv */
module bfe_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bfe_pkg::BYTE_W-1:0]     req_key_byte,
   input  logic                           csr_valid,
   input  logic [bfe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfe_pkg::FB_W-1:0]       csr_wdata,
   input  bfe_pkg::cmd_type               cmd,
   output bfe_pkg::status_type            st
);

   logic [bfe_pkg::FB_W-1:0]    filter_bits_ff;
   logic [bfe_pkg::HC_W-1:0]    hash_count_ff;
   logic [bfe_pkg::HASH_W-1:0]  h1_ff, h2_ff;
   logic [bfe_pkg::HASH_W-1:0]  h1_in, h2_in;
   logic [bfe_pkg::HASH_W-1:0]  acc_ff, dvd_ff, step_ff;
   logic [bfe_pkg::FB_W-1:0]    rem_ff, rem_in;
   logic [bfe_pkg::ADDR_W-1:0]  clr_addr_ff;
   logic                        rd_ff;
   logic [bfe_pkg::FB_W-1:0]    eff_bits;
   logic [bfe_pkg::HC_W-1:0]    eff_count;
   logic                        wr_en;
   logic                        wr_data;
   logic [bfe_pkg::ADDR_W-1:0]  wr_addr;
   logic [bfe_pkg::ADDR_W-1:0]  probe_addr;
   logic                        mem [bfe_pkg::MAX_FILTER_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= bfe_pkg::FB_W'(bfe_pkg::MAX_FILTER_BITS);
         hash_count_ff  <= bfe_pkg::HC_W'(2);
      end else if (csr_valid) begin
         if (csr_index == bfe_pkg::CSR_FILTER_BITS) begin
            filter_bits_ff <= csr_wdata;
         end
         if (csr_index == bfe_pkg::CSR_HASH_COUNT) begin
            hash_count_ff <= csr_wdata[bfe_pkg::HC_W-1:0];
         end
      end
   end

   always_comb begin
      if (filter_bits_ff == '0) begin
         eff_bits = bfe_pkg::FB_W'(1);
      end else if (filter_bits_ff > bfe_pkg::FB_W'(bfe_pkg::MAX_FILTER_BITS)) begin
         eff_bits = bfe_pkg::FB_W'(bfe_pkg::MAX_FILTER_BITS);
      end else begin
         eff_bits = filter_bits_ff;
      end
      if (hash_count_ff > bfe_pkg::HC_W'(bfe_pkg::MAX_HASHES)) begin
         eff_count = bfe_pkg::HC_W'(bfe_pkg::MAX_HASHES);
      end else begin
         eff_count = hash_count_ff;
      end
   end

   assign h1_in = (h1_ff << 5) + h1_ff + bfe_pkg::HASH_W'(req_key_byte);
   assign h2_in = (h2_ff << 5) - h2_ff + bfe_pkg::HASH_W'(req_key_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_ff <= bfe_pkg::DJB_START;
         h2_ff <= '0;
      end else if (cmd.load) begin
         h1_ff <= bfe_pkg::DJB_START;
         h2_ff <= '0;
      end else if (cmd.absorb) begin
         h1_ff <= h1_in;
         h2_ff <= h2_in;
      end
   end

   // remainder unit: DIV_BITS restoring steps per cycle, MSB first
   always_comb begin
      logic [bfe_pkg::FB_W:0] trial;
      rem_in = rem_ff;
      for (int k = 0; k < bfe_pkg::DIV_BITS; k++) begin
         trial = {rem_in, dvd_ff[bfe_pkg::HASH_W-1-k]};
         if (trial >= {1'b0, eff_bits}) begin
            trial = trial - {1'b0, eff_bits};
         end
         rem_in = trial[bfe_pkg::FB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dvd_ff  <= h1_in;
         acc_ff  <= h1_in + h2_in;
         step_ff <= h2_in;
         rem_ff  <= '0;
      end else if (cmd.next_probe) begin
         dvd_ff <= acc_ff;
         acc_ff <= acc_ff + step_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << bfe_pkg::DIV_BITS;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + bfe_pkg::ADDR_W'(1);
      end
   end

   assign probe_addr = rem_ff[bfe_pkg::ADDR_W-1:0];
   assign wr_en      = cmd.clear_step || cmd.write_bit;
   assign wr_data    = !cmd.clear_step;
   assign wr_addr    = cmd.clear_step ? clr_addr_ff : probe_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.read_bit) begin
         rd_ff <= mem[probe_addr];
      end
   end

   assign st.clear_last = (clr_addr_ff == '1);
   assign st.count      = eff_count;
   assign st.rd_bit     = rd_ff;

endmodule

/* rtl/bloom_filter_engine.sv */
// Bloom filter with double hashing, fed one key byte per beat. After reset the
// bit store is swept clear with req_stall held high; register writes are
// taken throughout. Non-final bytes are absorbed into both hashes as they are
// accepted. On the final byte the block derives hash_count probe positions
// (hash_count capped at 16); each goes through an iterative remainder unit that
// retires 4 dividend bits a cycle, then the store bit is written for an insert,
// or read and then tested for a query, which stops at the first clear bit. A
// query answer sits in an output register, and the block keeps taking beats
// while it waits to be taken; the next answer holds the block until then.
module bloom_filter_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [bfe_pkg::BYTE_W-1:0]     req_key_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_present,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bfe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfe_pkg::FB_W-1:0]       csr_wdata
);

   bfe_pkg::cmd_type    cmd;
   bfe_pkg::status_type st;

   assign csr_ready = 1'b1;

   bfe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_present   (rsp_present),
      .cmd           (cmd),
      .st            (st)
   );

   bfe_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_key_byte (req_key_byte),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .st           (st)
   );

endmodule
